>>> src/tcpa_pkg.sv
// ----------------------------------------------------------------------------
// tcpa_pkg: shared constants and types for the two-class pool allocator
// Field widths, pool geometry, stack sizing and request status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpa_pkg;

    // Pool geometry
    localparam int unsigned POOL_BLOCKS  = 1024;
    localparam int unsigned SMALL_LIMIT  = 15;
    localparam int unsigned LARGE_LIMIT  = 180;
    localparam int unsigned WORD_ALIGN   = 8;
    localparam int unsigned SMALL_STRIDE = ((SMALL_LIMIT + WORD_ALIGN - 1) / WORD_ALIGN)
                                           * WORD_ALIGN;
    localparam int unsigned LARGE_STRIDE = ((LARGE_LIMIT + WORD_ALIGN - 1) / WORD_ALIGN)
                                           * WORD_ALIGN;
    localparam int unsigned SMALL_SPAN   = POOL_BLOCKS * SMALL_STRIDE;
    localparam int unsigned LARGE_SPAN   = POOL_BLOCKS * LARGE_STRIDE;

    // Field widths
    localparam int unsigned OP_W    = 1;
    localparam int unsigned SIZE_W  = 16;
    localparam int unsigned ADDR_W  = 22;
    localparam int unsigned SBASE_W = 21;
    localparam int unsigned LBASE_W = 22;
    localparam int unsigned ST_W    = 3;
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned CDATA_W = 22;

    // Stack sizing
    localparam int unsigned CNT_W  = $clog2(POOL_BLOCKS + 1);
    localparam int unsigned IDX_W  = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
    localparam int unsigned SOFF_W = $clog2(SMALL_SPAN);
    localparam int unsigned LOFF_W = $clog2(LARGE_SPAN);

    // Reset values of the base registers
    localparam logic [SBASE_W-1:0] SMALL_BASE_RST = SBASE_W'(65536);
    localparam logic [LBASE_W-1:0] LARGE_BASE_RST = LBASE_W'(131072);

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC   = 1'b0;
    localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_SMALL_BASE = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_LARGE_BASE = 2'd1;

    // Request status codes
    typedef enum logic [ST_W-1:0] {
        ST_SMALL_GRANT = 3'd0,
        ST_LARGE_GRANT = 3'd1,
        ST_EMPTY       = 3'd2,
        ST_TOO_LARGE   = 3'd3,
        ST_RELEASED    = 3'd4,
        ST_NULL        = 3'd5,
        ST_FOREIGN     = 3'd6,
        ST_OVERFLOW    = 3'd7
    } t_status;

endpackage

`default_nettype wire

>>> src/tcpa_ram.sv
// ----------------------------------------------------------------------------
// tcpa_ram: generic single-clock RAM
// One write port and one read port; read data is registered and holds
// until the next read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic                                      i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, then registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/two_class_pool_allocator.sv
// ----------------------------------------------------------------------------
// two_class_pool_allocator: small/large fixed-size block pool allocator
// ----------------------------------------------------------------------------
// Each request either allocates a block (size selects the small or large
// pool) or releases a block address back to its pool. Every request yields
// exactly one response with a block address and a status code.
// Request channel: i_req_valid / o_req_stall, taken when valid and not stall.
// Response channel: o_rsp_valid / i_rsp_stall, held while stalled.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), index 0 writes the
// small pool base, index 1 the large pool base, other indexes are ignored.
// An allocate that pops a stack registers the stack memory read, then adds the
// pool base in S_READ and registers the response; all other requests answer
// in the next cycle. New requests stall while in S_READ; the stack memories'
// single read port and the free count chained between requests set this.
// Reset: both stacks read as full at once, block POOL_BLOCKS-1 on top; no
// clearing pass is needed, entries below the lowest stack depth reached since
// reset return their computed reset offset.
// A stalled response blocks new requests until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module two_class_pool_allocator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // request channel
    input  wire logic                            i_req_valid,
    output logic                                 o_req_stall,
    input  wire logic [tcpa_pkg::OP_W-1:0]       i_operation,
    input  wire logic [tcpa_pkg::SIZE_W-1:0]     i_request_size,
    input  wire logic [tcpa_pkg::ADDR_W-1:0]     i_release_address,
    // response channel
    output logic                                 o_rsp_valid,
    input  wire logic                            i_rsp_stall,
    output logic      [tcpa_pkg::ADDR_W-1:0]     o_block_address,
    output logic      [tcpa_pkg::ST_W-1:0]       o_status,
    // config channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tcpa_pkg::CIDX_W-1:0]     i_cfg_index,
    input  wire logic [tcpa_pkg::CDATA_W-1:0]    i_cfg_data
);

    localparam int unsigned AW  = tcpa_pkg::ADDR_W;
    localparam int unsigned CW  = tcpa_pkg::CNT_W;
    localparam int unsigned IW  = tcpa_pkg::IDX_W;
    localparam int unsigned SW  = tcpa_pkg::SOFF_W;
    localparam int unsigned LW  = tcpa_pkg::LOFF_W;
    localparam logic [CW-1:0] CNT_FULL = CW'(tcpa_pkg::POOL_BLOCKS);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    // Registers
    t_state                          r_state, n_state;
    logic [tcpa_pkg::SBASE_W-1:0]    r_small_base;
    logic [tcpa_pkg::LBASE_W-1:0]    r_large_base;
    logic [CW-1:0]                   r_s_cnt, n_s_cnt;
    logic [CW-1:0]                   r_l_cnt, n_l_cnt;
    logic [CW-1:0]                   r_s_low, n_s_low;
    logic [CW-1:0]                   r_l_low, n_l_low;
    logic                            r_pop_large, n_pop_large;
    logic                            r_fill_sel, n_fill_sel;
    logic [LW-1:0]                   r_fill_off, n_fill_off;
    logic                            r_rsp_valid, n_rsp_valid;
    logic [AW-1:0]                   r_rsp_addr, n_rsp_addr;
    logic [tcpa_pkg::ST_W-1:0]       r_rsp_status, n_rsp_status;

    // Memory ports
    logic          s_we, s_re, l_we, l_re;
    logic [IW-1:0] s_waddr, s_raddr, l_waddr, l_raddr;
    logic [SW-1:0] s_wdata, s_rdata;
    logic [LW-1:0] l_wdata, l_rdata;

    // Request decode
    logic          out_free;
    logic          req_fire;
    logic [CW-1:0] s_top, l_top;
    logic [AW:0]   s_diff, l_diff;
    logic          in_small, in_large;
    logic [LW-1:0] pop_off;
    logic [AW:0]   grant_sum;

    assign out_free    = !r_rsp_valid || !i_rsp_stall;
    assign o_req_stall = (r_state != S_IDLE) || !out_free;
    assign req_fire    = i_req_valid && !o_req_stall;
    assign o_cfg_ready = 1'b1;

    assign o_rsp_valid     = r_rsp_valid;
    assign o_block_address = r_rsp_addr;
    assign o_status        = r_rsp_status;

    assign s_top  = r_s_cnt - CW'(1);
    assign l_top  = r_l_cnt - CW'(1);
    assign s_diff = {1'b0, i_release_address} - (AW + 1)'(r_small_base);
    assign l_diff = {1'b0, i_release_address} - (AW + 1)'(r_large_base);
    assign in_small = !s_diff[AW] && (s_diff < (AW + 1)'(tcpa_pkg::SMALL_SPAN));
    assign in_large = !l_diff[AW] && (l_diff < (AW + 1)'(tcpa_pkg::LARGE_SPAN));

    // Popped offset: memory entry, or reset offset for never-written entries
    always_comb begin
        if (r_fill_sel) begin
            pop_off = r_fill_off;
        end else if (r_pop_large) begin
            pop_off = l_rdata;
        end else begin
            pop_off = LW'(s_rdata);
        end
    end

    always_comb begin
        if (r_pop_large) begin
            grant_sum = (AW + 1)'(r_large_base) + (AW + 1)'(pop_off);
        end else begin
            grant_sum = (AW + 1)'(r_small_base) + (AW + 1)'(pop_off);
        end
    end

    // Next-state logic
    always_comb begin
        n_state      = r_state;
        n_s_cnt      = r_s_cnt;
        n_l_cnt      = r_l_cnt;
        n_s_low      = r_s_low;
        n_l_low      = r_l_low;
        n_pop_large  = r_pop_large;
        n_fill_sel   = r_fill_sel;
        n_fill_off   = r_fill_off;
        n_rsp_valid  = r_rsp_valid && i_rsp_stall;
        n_rsp_addr   = r_rsp_addr;
        n_rsp_status = r_rsp_status;
        s_we    = 1'b0;
        s_re    = 1'b0;
        l_we    = 1'b0;
        l_re    = 1'b0;
        s_waddr = r_s_cnt[IW-1:0];
        l_waddr = r_l_cnt[IW-1:0];
        s_raddr = s_top[IW-1:0];
        l_raddr = l_top[IW-1:0];
        s_wdata = s_diff[SW-1:0];
        l_wdata = l_diff[LW-1:0];

        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_rsp_addr = '0;
                    if (i_operation == tcpa_pkg::OP_ALLOC) begin
                        if (i_request_size <= tcpa_pkg::SIZE_W'(tcpa_pkg::SMALL_LIMIT)) begin
                            if (r_s_cnt == '0) begin
                                n_rsp_valid  = 1'b1;
                                n_rsp_status = tcpa_pkg::ST_EMPTY;
                            end else begin
                                // pop small stack
                                s_re        = 1'b1;
                                n_s_cnt     = s_top;
                                n_pop_large = 1'b0;
                                n_fill_sel  = s_top < r_s_low;
                                n_fill_off  = LW'(s_top[IW-1:0] * tcpa_pkg::SMALL_STRIDE);
                                if (s_top < r_s_low) begin
                                    n_s_low = s_top;
                                end
                                n_state = S_READ;
                            end
                        end else if (i_request_size
                                     <= tcpa_pkg::SIZE_W'(tcpa_pkg::LARGE_LIMIT)) begin
                            if (r_l_cnt == '0) begin
                                n_rsp_valid  = 1'b1;
                                n_rsp_status = tcpa_pkg::ST_EMPTY;
                            end else begin
                                // pop large stack
                                l_re        = 1'b1;
                                n_l_cnt     = l_top;
                                n_pop_large = 1'b1;
                                n_fill_sel  = l_top < r_l_low;
                                n_fill_off  = LW'(l_top[IW-1:0] * tcpa_pkg::LARGE_STRIDE);
                                if (l_top < r_l_low) begin
                                    n_l_low = l_top;
                                end
                                n_state = S_READ;
                            end
                        end else begin
                            n_rsp_valid  = 1'b1;
                            n_rsp_status = tcpa_pkg::ST_TOO_LARGE;
                        end
                    end else begin
                        n_rsp_valid = 1'b1;
                        if (i_release_address == '0) begin
                            n_rsp_status = tcpa_pkg::ST_NULL;
                        end else if (in_small) begin
                            if (r_s_cnt == CNT_FULL) begin
                                n_rsp_status = tcpa_pkg::ST_OVERFLOW;
                            end else begin
                                // push small stack
                                s_we         = 1'b1;
                                n_s_cnt      = r_s_cnt + CW'(1);
                                n_rsp_status = tcpa_pkg::ST_RELEASED;
                            end
                        end else if (in_large) begin
                            if (r_l_cnt == CNT_FULL) begin
                                n_rsp_status = tcpa_pkg::ST_OVERFLOW;
                            end else begin
                                // push large stack
                                l_we         = 1'b1;
                                n_l_cnt      = r_l_cnt + CW'(1);
                                n_rsp_status = tcpa_pkg::ST_RELEASED;
                            end
                        end else begin
                            n_rsp_status = tcpa_pkg::ST_FOREIGN;
                        end
                    end
                end
            end
            S_READ: begin
                // form the granted address once the response slot is free
                if (out_free) begin
                    n_rsp_valid  = 1'b1;
                    n_rsp_addr   = grant_sum[AW-1:0];
                    n_rsp_status = r_pop_large ? tcpa_pkg::ST_LARGE_GRANT
                                               : tcpa_pkg::ST_SMALL_GRANT;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_small_base <= tcpa_pkg::SMALL_BASE_RST;
            r_large_base <= tcpa_pkg::LARGE_BASE_RST;
            r_s_cnt      <= CNT_FULL;
            r_l_cnt      <= CNT_FULL;
            r_s_low      <= CNT_FULL;
            r_l_low      <= CNT_FULL;
            r_pop_large  <= 1'b0;
            r_fill_sel   <= 1'b0;
            r_fill_off   <= '0;
            r_rsp_valid  <= 1'b0;
            r_rsp_addr   <= '0;
            r_rsp_status <= tcpa_pkg::ST_SMALL_GRANT;
        end else begin
            r_state      <= n_state;
            r_s_cnt      <= n_s_cnt;
            r_l_cnt      <= n_l_cnt;
            r_s_low      <= n_s_low;
            r_l_low      <= n_l_low;
            r_pop_large  <= n_pop_large;
            r_fill_sel   <= n_fill_sel;
            r_fill_off   <= n_fill_off;
            r_rsp_valid  <= n_rsp_valid;
            r_rsp_addr   <= n_rsp_addr;
            r_rsp_status <= n_rsp_status;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == tcpa_pkg::CFG_SMALL_BASE) begin
                    r_small_base <= i_cfg_data[tcpa_pkg::SBASE_W-1:0];
                end else if (i_cfg_index == tcpa_pkg::CFG_LARGE_BASE) begin
                    r_large_base <= i_cfg_data[tcpa_pkg::LBASE_W-1:0];
                end
            end
        end
    end

    // Free stacks
    tcpa_ram #(
        .WIDTH (SW),
        .DEPTH (tcpa_pkg::POOL_BLOCKS)
    ) u_small_stack (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    tcpa_ram #(
        .WIDTH (LW),
        .DEPTH (tcpa_pkg::POOL_BLOCKS)
    ) u_large_stack (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_re    (l_re),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

endmodule

`default_nettype wire

>>> tb/two_class_pool_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_class_pool_allocator_tb: self-checking bench for the two-class allocator
// Drives allocate and release requests and pool base writes through the
// block's ports. A ledger tracks both free stacks and the base registers and
// checks every response in order. Sender and receiver idle at random, and the
// receiver stalls for a long stretch once to back the block up. Directed
// requests hit the field extremes and the special cases. Then random requests
// run, mostly allocates and releases of granted blocks, across several base
// settings, overlapping pools among them. One pass returns every granted block
// and then pushes more offsets onto the stacks.
// ----------------------------------------------------------------------------

module two_class_pool_allocator_tb;

    localparam int SMALL_POOL  = 0;
    localparam int LARGE_POOL  = 1;
    localparam int QUIET_LIMIT = 2000;

    // Indexes that the block ignores
    localparam logic [tcpa_pkg::CIDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [tcpa_pkg::CIDX_W-1:0] CFG_SPARE_B = 2'd3;

    // ------------------------------------------------------------------------
    // Ledger: free stacks, base registers and the responses still owed
    // ------------------------------------------------------------------------
    class pool_ledger;
        typedef struct packed {
            logic [tcpa_pkg::ADDR_W-1:0] addr;
            tcpa_pkg::t_status           status;
        } t_response;

        bit [tcpa_pkg::ADDR_W-1:0] base[2];
        bit [tcpa_pkg::LOFF_W-1:0] stack[2][tcpa_pkg::POOL_BLOCKS];
        bit [tcpa_pkg::CNT_W-1:0]  count[2];
        int unsigned               live[2][$];
        t_response                 owed_responses[$];
        int                        errors;

        function new();
            base[SMALL_POOL] = tcpa_pkg::ADDR_W'(tcpa_pkg::SMALL_BASE_RST);
            base[LARGE_POOL] = tcpa_pkg::LARGE_BASE_RST;
            for (int i = 0; i < tcpa_pkg::POOL_BLOCKS; i++) begin
                stack[SMALL_POOL][i] = tcpa_pkg::LOFF_W'(i * tcpa_pkg::SMALL_STRIDE);
                stack[LARGE_POOL][i] = tcpa_pkg::LOFF_W'(i * tcpa_pkg::LARGE_STRIDE);
            end
            count[SMALL_POOL] = tcpa_pkg::CNT_W'(tcpa_pkg::POOL_BLOCKS);
            count[LARGE_POOL] = tcpa_pkg::CNT_W'(tcpa_pkg::POOL_BLOCKS);
            errors = 0;
        endfunction

        function int unsigned span_of(int p);
            return (p == SMALL_POOL) ? tcpa_pkg::SMALL_SPAN : tcpa_pkg::LARGE_SPAN;
        endfunction

        function bit in_pool(int p, logic [tcpa_pkg::ADDR_W-1:0] addr);
            bit [31:0] a;
            a = addr;
            return a >= base[p] && a - base[p] < span_of(p);
        endfunction

        // Mask the small base to its register width, drop other indexes
        function void write_register(logic [tcpa_pkg::CIDX_W-1:0] idx,
                                     logic [tcpa_pkg::CDATA_W-1:0] data);
            case (idx)
                tcpa_pkg::CFG_SMALL_BASE:
                    base[SMALL_POOL] = tcpa_pkg::ADDR_W'(data[tcpa_pkg::SBASE_W-1:0]);
                tcpa_pkg::CFG_LARGE_BASE:
                    base[LARGE_POOL] = data[tcpa_pkg::LBASE_W-1:0];
                default: ;
            endcase
        endfunction

        // Push an offset unless the stack is full
        function tcpa_pkg::t_status push_offset(int p, bit [31:0] off);
            if (count[p] >= tcpa_pkg::POOL_BLOCKS)
                return tcpa_pkg::ST_OVERFLOW;
            stack[p][count[p]] = off[tcpa_pkg::LOFF_W-1:0];
            count[p]++;
            return tcpa_pkg::ST_RELEASED;
        endfunction

        // Work out the response to one accepted request and queue it
        function void apply_request(logic op, logic [tcpa_pkg::SIZE_W-1:0] size,
                                    logic [tcpa_pkg::ADDR_W-1:0] addr);
            t_response r;
            int        p;
            bit [31:0] sum;
            r.addr = '0;
            if (op == tcpa_pkg::OP_ALLOC) begin
                p = (size <= tcpa_pkg::SMALL_LIMIT) ? SMALL_POOL : LARGE_POOL;
                if (size > tcpa_pkg::LARGE_LIMIT) begin
                    r.status = tcpa_pkg::ST_TOO_LARGE;
                end else if (count[p] == 0) begin
                    r.status = tcpa_pkg::ST_EMPTY;
                end else begin
                    count[p]--;
                    sum = base[p] + stack[p][count[p]];
                    r.addr = sum[tcpa_pkg::ADDR_W-1:0];
                    r.status = (p == SMALL_POOL) ? tcpa_pkg::ST_SMALL_GRANT
                                                 : tcpa_pkg::ST_LARGE_GRANT;
                    live[p].push_back(stack[p][count[p]]);
                end
            end else begin
                // Null first, then the small range, then the large range
                if (addr == '0)
                    r.status = tcpa_pkg::ST_NULL;
                else if (in_pool(SMALL_POOL, addr))
                    r.status = push_offset(SMALL_POOL, addr - base[SMALL_POOL]);
                else if (in_pool(LARGE_POOL, addr))
                    r.status = push_offset(LARGE_POOL, addr - base[LARGE_POOL]);
                else
                    r.status = tcpa_pkg::ST_FOREIGN;
            end
            owed_responses.push_back(r);
        endfunction

        // Remove a granted block at random and return its current address
        function logic [tcpa_pkg::ADDR_W-1:0] take_live(int p);
            int unsigned k;
            bit [31:0]   sum;
            k = $urandom_range(live[p].size() - 1);
            sum = base[p] + live[p][k];
            live[p].delete(k);
            return sum[tcpa_pkg::ADDR_W-1:0];
        endfunction

        task report(string msg);
            errors++;
            $display("%0t ns mismatch: %s", $time, msg);
        endtask

        task check_response(logic [tcpa_pkg::ADDR_W-1:0] addr,
                            logic [tcpa_pkg::ST_W-1:0] status);
            t_response r;
            if (owed_responses.size() == 0) begin
                report($sformatf("response addr %h status %0d with no request pending",
                                 addr, status));
                return;
            end
            r = owed_responses.pop_front();
            if (addr !== r.addr)
                report($sformatf("block address %h, predicted %h", addr, r.addr));
            if (status !== r.status)
                report($sformatf("status %0d, predicted %0d", status, r.status));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block
    // ------------------------------------------------------------------------
    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          req_valid = 1'b0;
    logic                          req_stall;
    logic [tcpa_pkg::OP_W-1:0]     operation = tcpa_pkg::OP_ALLOC;
    logic [tcpa_pkg::SIZE_W-1:0]   request_size = '0;
    logic [tcpa_pkg::ADDR_W-1:0]   release_address = '0;
    logic                          rsp_valid;
    logic                          rsp_stall = 1'b0;
    logic [tcpa_pkg::ADDR_W-1:0]   block_address;
    logic [tcpa_pkg::ST_W-1:0]     status;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [tcpa_pkg::CIDX_W-1:0]   cfg_index = tcpa_pkg::CFG_SMALL_BASE;
    logic [tcpa_pkg::CDATA_W-1:0]  cfg_data = '0;

    int unsigned req_idle_pct = 0;
    int unsigned rsp_idle_pct = 0;
    int unsigned rsp_hold_cycles = 0;
    int unsigned quiet_cycles = 0;
    pool_ledger  ledger;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    two_class_pool_allocator dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_req_valid       (req_valid),
        .o_req_stall       (req_stall),
        .i_operation       (operation),
        .i_request_size    (request_size),
        .i_release_address (release_address),
        .o_rsp_valid       (rsp_valid),
        .i_rsp_stall       (rsp_stall),
        .o_block_address   (block_address),
        .o_status          (status),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Receiver: hold off for a counted stretch, else stall at random
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (rsp_hold_cycles != 0) begin
            rsp_stall = 1'b1;
            rsp_hold_cycles = rsp_hold_cycles - 1;
        end else begin
            rsp_stall = ($urandom_range(99) < rsp_idle_pct);
        end
    end

    // Check each response taken
    always @(posedge clk) begin
        if (rst_n && rsp_valid && !rsp_stall)
            ledger.check_response(block_address, status);
    end

    // Abort when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("two_class_pool_allocator_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one request, idling first at random, and hold it until taken
    task automatic send_request(logic op, logic [tcpa_pkg::SIZE_W-1:0] size,
                                logic [tcpa_pkg::ADDR_W-1:0] addr);
        @(negedge clk);
        while ($urandom_range(99) < req_idle_pct) begin
            req_valid = 1'b0;
            operation = tcpa_pkg::OP_W'($urandom);
            request_size = tcpa_pkg::SIZE_W'($urandom);
            release_address = tcpa_pkg::ADDR_W'($urandom);
            @(negedge clk);
        end
        req_valid = 1'b1;
        operation = op;
        request_size = size;
        release_address = addr;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        ledger.apply_request(op, size, addr);
    endtask

    task automatic write_register(logic [tcpa_pkg::CIDX_W-1:0] idx,
                                  logic [tcpa_pkg::CDATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        ledger.write_register(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Drop valid and wait until every owed response is in, plus the latency
    task automatic settle();
        @(negedge clk);
        req_valid = 1'b0;
        while (ledger.owed_responses.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly allocates and releases of granted blocks, some noise
    task automatic random_request();
        int unsigned                   pick;
        int                            p;
        logic                          op;
        logic [tcpa_pkg::SIZE_W-1:0]   size;
        logic [tcpa_pkg::ADDR_W-1:0]   addr;
        bit [31:0]                     sum;
        size = tcpa_pkg::SIZE_W'($urandom);
        addr = tcpa_pkg::ADDR_W'($urandom);
        p = $urandom_range(1);
        pick = $urandom_range(9);
        if ($urandom_range(99) < 50) begin
            op = tcpa_pkg::OP_ALLOC;
            if (pick < 4) begin
                size = tcpa_pkg::SIZE_W'($urandom_range(tcpa_pkg::SMALL_LIMIT));
            end else if (pick < 8) begin
                size = tcpa_pkg::SIZE_W'($urandom_range(tcpa_pkg::LARGE_LIMIT,
                                                        tcpa_pkg::SMALL_LIMIT + 1));
            end else if (pick == 8) begin
                case ($urandom_range(3))
                    0: size = tcpa_pkg::SIZE_W'(tcpa_pkg::SMALL_LIMIT);
                    1: size = tcpa_pkg::SIZE_W'(tcpa_pkg::SMALL_LIMIT + 1);
                    2: size = tcpa_pkg::SIZE_W'(tcpa_pkg::LARGE_LIMIT);
                    default: size = tcpa_pkg::SIZE_W'(tcpa_pkg::LARGE_LIMIT + 1);
                endcase
            end
        end else begin
            op = tcpa_pkg::OP_RELEASE;
            if (pick < 6 && ledger.live[p].size() == 0)
                p = 1 - p;
            if (pick < 6 && ledger.live[p].size() != 0) begin
                addr = ledger.take_live(p);
            end else if (pick == 6) begin
                addr = '0;
            end else if (pick < 8) begin
                // Anywhere in a pool: double frees and unaligned offsets
                sum = ledger.base[p] + $urandom_range(ledger.span_of(p) - 1);
                addr = sum[tcpa_pkg::ADDR_W-1:0];
            end else if (pick == 9) begin
                // Just outside a pool
                sum = $urandom_range(1) ? ledger.base[p] - 1
                                        : ledger.base[p] + ledger.span_of(p);
                addr = sum[tcpa_pkg::ADDR_W-1:0];
            end
        end
        send_request(op, size, addr);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        int p;
        bit [31:0] sum;
        ledger = new();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed requests at the reset bases
        req_idle_pct = 25;
        rsp_idle_pct = 54;
        send_request(tcpa_pkg::OP_ALLOC, 16'd0, tcpa_pkg::ADDR_W'($urandom));
        send_request(tcpa_pkg::OP_ALLOC, tcpa_pkg::SIZE_W'(tcpa_pkg::SMALL_LIMIT), '1);
        send_request(tcpa_pkg::OP_ALLOC, tcpa_pkg::SIZE_W'(tcpa_pkg::SMALL_LIMIT + 1), '0);
        send_request(tcpa_pkg::OP_ALLOC, tcpa_pkg::SIZE_W'(tcpa_pkg::LARGE_LIMIT),
                     tcpa_pkg::ADDR_W'($urandom));
        send_request(tcpa_pkg::OP_ALLOC, tcpa_pkg::SIZE_W'(tcpa_pkg::LARGE_LIMIT + 1),
                     tcpa_pkg::ADDR_W'($urandom));
        send_request(tcpa_pkg::OP_ALLOC, '1, tcpa_pkg::ADDR_W'($urandom));
        send_request(tcpa_pkg::OP_RELEASE, '1, '0);
        send_request(tcpa_pkg::OP_RELEASE, '0, 22'd1);
        send_request(tcpa_pkg::OP_RELEASE, tcpa_pkg::SIZE_W'($urandom), '1);
        send_request(tcpa_pkg::OP_RELEASE, tcpa_pkg::SIZE_W'($urandom),
                     tcpa_pkg::ADDR_W'(tcpa_pkg::SMALL_BASE_RST - 1));
        send_request(tcpa_pkg::OP_RELEASE, tcpa_pkg::SIZE_W'($urandom),
                     tcpa_pkg::ADDR_W'(tcpa_pkg::SMALL_BASE_RST + tcpa_pkg::SMALL_SPAN));
        send_request(tcpa_pkg::OP_RELEASE, tcpa_pkg::SIZE_W'($urandom),
                     tcpa_pkg::ADDR_W'(tcpa_pkg::LARGE_BASE_RST + tcpa_pkg::LARGE_SPAN));
        send_request(tcpa_pkg::OP_RELEASE, tcpa_pkg::SIZE_W'($urandom), 22'h200000);
        send_request(tcpa_pkg::OP_RELEASE, tcpa_pkg::SIZE_W'($urandom),
                     ledger.take_live(SMALL_POOL));
        send_request(tcpa_pkg::OP_RELEASE, tcpa_pkg::SIZE_W'($urandom),
                     ledger.take_live(LARGE_POOL));
        // Unaligned release fills the small stack, block zero is then a double free
        send_request(tcpa_pkg::OP_RELEASE, tcpa_pkg::SIZE_W'($urandom),
                     tcpa_pkg::ADDR_W'(tcpa_pkg::SMALL_BASE_RST + 5));
        send_request(tcpa_pkg::OP_RELEASE, tcpa_pkg::SIZE_W'($urandom),
                     tcpa_pkg::ADDR_W'(tcpa_pkg::SMALL_BASE_RST));
        send_request(tcpa_pkg::OP_ALLOC, 16'd7, tcpa_pkg::ADDR_W'($urandom));
        // Last byte of the large pool comes back as a grant
        send_request(tcpa_pkg::OP_RELEASE, tcpa_pkg::SIZE_W'($urandom),
                     tcpa_pkg::ADDR_W'(tcpa_pkg::LARGE_BASE_RST + tcpa_pkg::LARGE_SPAN - 1));
        send_request(tcpa_pkg::OP_ALLOC, 16'd100, tcpa_pkg::ADDR_W'($urandom));
        send_request(tcpa_pkg::OP_RELEASE, tcpa_pkg::SIZE_W'($urandom),
                     tcpa_pkg::ADDR_W'(tcpa_pkg::LARGE_BASE_RST));
        send_request(tcpa_pkg::OP_RELEASE, tcpa_pkg::SIZE_W'($urandom),
                     tcpa_pkg::ADDR_W'(tcpa_pkg::LARGE_BASE_RST));
        settle();

        // Low small base, high large base, writes to unused indexes
        write_register(tcpa_pkg::CFG_SMALL_BASE, 22'd1);
        write_register(tcpa_pkg::CFG_LARGE_BASE, 22'd2097152);
        write_register(CFG_SPARE_A, 22'h155555);
        write_register(CFG_SPARE_B, 22'h2AAAAA);
        rsp_hold_cycles = 300;
        repeat (250) random_request();
        settle();

        // Large pool overlaps the small one, small range wins
        req_idle_pct = 54;
        rsp_idle_pct = 25;
        write_register(tcpa_pkg::CFG_SMALL_BASE, 22'd1048576);
        write_register(tcpa_pkg::CFG_LARGE_BASE, 22'd1048584);
        repeat (250) random_request();
        settle();

        // Top small base through masking, large pool at address zero
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        write_register(tcpa_pkg::CFG_SMALL_BASE, '1);
        write_register(tcpa_pkg::CFG_LARGE_BASE, '0);
        repeat (150) random_request();

        // Return every granted block, then push more offsets
        while (ledger.live[SMALL_POOL].size() + ledger.live[LARGE_POOL].size() != 0) begin
            p = $urandom_range(1);
            if (ledger.live[p].size() == 0)
                p = 1 - p;
            send_request(tcpa_pkg::OP_RELEASE, tcpa_pkg::SIZE_W'($urandom),
                         ledger.take_live(p));
        end
        repeat (8) begin
            p = $urandom_range(1);
            sum = ledger.base[p] + $urandom_range(ledger.span_of(p) - 1, 1);
            send_request(tcpa_pkg::OP_RELEASE, tcpa_pkg::SIZE_W'($urandom),
                         sum[tcpa_pkg::ADDR_W-1:0]);
        end
        settle();

        // Top large base, grants wrap around the address space
        write_register(tcpa_pkg::CFG_LARGE_BASE, '1);
        repeat (150) random_request();
        settle();
        repeat (8) @(posedge clk);

        if (ledger.owed_responses.size() != 0)
            ledger.report($sformatf("%0d responses never arrived",
                                    ledger.owed_responses.size()));
        if (ledger.errors == 0)
            $display("two_class_pool_allocator_tb: done, clean");
        else
            $display("two_class_pool_allocator_tb: done, errors");
        $finish;
    end

endmodule

>>> files.f
src/tcpa_pkg.sv
src/tcpa_ram.sv
src/two_class_pool_allocator.sv
tb/two_class_pool_allocator_tb.sv
